@@ hdl/sic_pkg.sv @@
package sic_pkg;

  localparam int VALUE_W   = 32;
  localparam int MAX_ITEMS = 1024;
  // wide enough to hold MAX_ITEMS itself
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int TOTAL_W   = 19;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // one item travelling down the cell row
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic                      final_item;
    logic                      placed;   // already stored, or dropped at entry
    logic                      ovf;      // overflow seen in this sequence so far
    logic [CNT_W-1:0]          count;    // stored elements greater than value
  } slot_t;

endpackage

@@ hdl/sic_in_if.sv @@
interface sic_in_if import sic_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink (input valid, input value, input final_item, output ready);
endinterface

@@ hdl/sic_out_if.sv @@
interface sic_out_if import sic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] running_total;
  logic               done_res;
  logic               overflowed;

  modport source (output valid, output running_total, output done_res, output overflowed,
                  input ready);
  modport sink (input valid, input running_total, input done_res, input overflowed,
                output ready);
endinterface

@@ hdl/sic_entry.sv @@
module sic_entry import sic_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      final_item,
  output slot_t                     slot
);

  logic [CNT_W-1:0] stored_count;
  logic             overflow_seen;
  logic             full;

  assign full = (stored_count == CNT_W'(MAX_ITEMS));

  always_comb begin
    slot.valid      = accept;
    slot.value      = value;
    slot.final_item = final_item;
    slot.placed     = full;
    slot.ovf        = overflow_seen | full;
    slot.count      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (final_item) begin
        stored_count  <= '0;
        overflow_seen <= 1'b0;
      end else if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        stored_count <= stored_count + CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/sic_cell.sv @@
module sic_cell import sic_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  slot_t slot_in,
  output slot_t slot_out
);

  logic                      occupied;
  logic                      occupied_next;
  logic signed [VALUE_W-1:0] elem;
  logic                      take;
  slot_t                     slot_next;

  // first free cell keeps the element
  assign take = slot_in.valid && !slot_in.placed && !occupied;

  always_comb begin
    slot_next     = slot_in;
    occupied_next = occupied;
    if (slot_in.valid) begin
      if (!slot_in.placed) begin
        if (occupied) begin
          if (elem > slot_in.value) slot_next.count = slot_in.count + CNT_W'(1);
        end else begin
          occupied_next    = 1'b1;
          slot_next.placed = 1'b1;
        end
      end
      // end of sequence empties the cell behind the item
      if (slot_in.final_item) occupied_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take) elem <= slot_in.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied       <= 1'b0;
      slot_out.valid <= 1'b0;
    end else if (advance) begin
      occupied <= occupied_next;
      slot_out <= slot_next;
    end
  end

endmodule

@@ hdl/sic_tally.sv @@
module sic_tally import sic_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  slot_t      tail,
  output logic       advance,
  sic_out_if.source  results
);

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_sat;

  assign advance   = !results.valid || results.ready;
  assign sum       = {1'b0, total} + (TOTAL_W + 1)'(tail.count);
  assign total_sat = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (advance && tail.valid) begin
      results.running_total <= total_sat;
      results.done_res      <= tail.final_item;
      results.overflowed    <= tail.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      total         <= '0;
    end else if (advance) begin
      results.valid <= tail.valid;
      if (tail.valid) total <= tail.final_item ? '0 : total_sat;
    end
  end

endmodule

@@ hdl/stream_inversion_counter_core.sv @@
// stream inversion counter: counts pairs i<j of one sequence where the later
// element is strictly less than the earlier one (signed 32-bit compare). each
// input item carries one element and returns one result with the running
// total, the final_item mark as done_res, and an overflow flag that is set
// once an element arrived with MAX_ITEMS elements already stored (such an
// element is ignored). the block takes one item per cycle while no result
// is stalled; each item walks a row of MAX_ITEMS compare cells, one cell
// per cycle, and its result is registered after the last cell. a stalled
// result halts the whole row.
// no clearing pass after reset: cells come up empty and the final item
// empties each cell as it passes, ahead of the next sequence.
module stream_inversion_counter_core import sic_pkg::*; (
  input logic      clk,
  input logic      rst,
  sic_in_if.sink   items,
  sic_out_if.source results
);

  logic  advance;
  logic  accept;
  // link[k] feeds cell k; link[MAX_ITEMS] leaves the last cell
  slot_t link [MAX_ITEMS+1];

  // the whole row moves together whenever the result register can take a slot
  assign items.ready = advance && !rst;
  assign accept      = items.valid && items.ready;

  // admission: tracks the fill of the row and marks items that find it full
  sic_entry u_entry (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .value      (items.value),
    .final_item (items.final_item),
    .slot       (link[0])
  );

  // compare cells: each holds one stored element and counts larger ones
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    sic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .slot_in  (link[k]),
      .slot_out (link[k+1])
    );
  end

  // running total and result register
  sic_tally u_tally (
    .clk     (clk),
    .rst     (rst),
    .tail    (link[MAX_ITEMS]),
    .advance (advance),
    .results (results)
  );

endmodule

@@ hdl/sic_checker.sv @@
module sic_checker import sic_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TOTAL_W-1:0] out_total,
  input logic               out_done,
  input logic               out_ovf
);

  // a waiting result holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_total) && $stable(out_done)
      && $stable(out_ovf))
    else $error("result changed while stalled");

  // a stalled result freezes the cell row, so no item may enter
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item accepted while row is stalled");

  // with the result register empty the row always moves
  assert property (@(posedge clk) disable iff (rst)
    !out_valid && !rst |-> in_ready)
    else $error("input stalled with empty result register");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind stream_inversion_counter_core sic_checker u_sic_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_total (results.running_total),
  .out_done  (results.done_res),
  .out_ovf   (results.overflowed)
);
